// File: rtl/core/lwfs_pkg.sv
package lwfs_pkg;

    // Field widths of the streams and of the configuration registers.
    localparam int RANGE_W   = 16;
    localparam int FUNC_W    = 2;
    localparam int MOUNT_W   = 11;
    localparam int CFG_ANG_W = 16;
    localparam int SPEED_W   = 8;
    localparam int TURN_W    = 12;
    localparam int DEC_W     = 2;

    // Digit-serial multiplier: the range is consumed four bits per cycle.
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = RANGE_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);

    // Q0.15 sine entries and the products built from them.
    localparam int Q15_W      = 16;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 16384;
    localparam int ACC_W      = RANGE_W + Q15_W + 1;
    localparam int COORD_W    = 18;

    // Quarter-wave polynomial coefficients in Q15.
    localparam longint POLY_C1 = 51466;
    localparam longint POLY_C3 = 21077;
    localparam longint POLY_C5 = 2383;
    localparam longint Q15_MAX = 32767;

    // Geometry limits, in millimetres.
    localparam logic signed [COORD_W-1:0] COORD_ZERO        = 18'sd0;
    localparam logic signed [COORD_W-1:0] COORD_RADIUS      = 18'sd200;
    localparam logic signed [COORD_W-1:0] COORD_SIDE_LIMIT  = 18'sd500;
    localparam logic signed [COORD_W-1:0] COORD_APPROACH_MX = 18'sd500;

    localparam int SIDE_W  = 9;
    localparam int FRONT_W = 10;
    localparam logic [FRONT_W-1:0] FRONT_NONE        = 10'd1023;
    localparam logic [FRONT_W-1:0] FRONT_APPROACH_MN = 10'd300;
    localparam logic [FRONT_W-1:0] FRONT_APPROACH_MX = 10'd500;
    localparam logic [SIDE_W-1:0]  RADIUS_U          = 9'd200;

    // Blend arithmetic: speed = (prod + 160) / 320, done as >>6 then /5 by reciprocal.
    localparam int PROD_W          = 17;
    localparam int SPEED_BIAS      = 160;
    localparam int SPEED_PRE_SHIFT = 6;
    localparam int QUOT_W          = PROD_W - SPEED_PRE_SHIFT;
    localparam int RECIP5          = 52429;
    localparam int RECIP_SHIFT     = 18;
    localparam int RECIP_W         = QUOT_W + 16;
    localparam int VTURN_W         = 13;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 12'sd1400;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXPLORE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HALT    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_OTHER   = 2'd3;

    // Decision codes.
    localparam logic [DEC_W-1:0] DEC_STOP    = 2'd0;
    localparam logic [DEC_W-1:0] DEC_NO_SIDE = 2'd1;
    localparam logic [DEC_W-1:0] DEC_BLOCKED = 2'd2;
    localparam logic [DEC_W-1:0] DEC_BLEND   = 2'd3;

    // Configuration register indexes.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FOLLOW_RIGHT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_ANGLE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MOUNT_X      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MOUNT_Y      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MOUNT_YAW    = 3'd5;

    localparam logic [CFG_ANG_W-1:0] ANGLE_STEP_RESET = 16'd182;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

// File: rtl/core/lwfs_point.sv
module lwfs_point #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ANGLE_BITS       = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [ANGLE_BITS-1:0]                  ang,
    input  logic [lwfs_pkg::RANGE_W-1:0]           range_mm,
    input  logic signed [lwfs_pkg::MOUNT_W-1:0]    mount_x_mm,
    input  logic signed [lwfs_pkg::MOUNT_W-1:0]    mount_y_mm,
    output logic                                   done,
    output lwfs_pkg::point_t                       point
);
    import lwfs_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int IPROD_W = ANGLE_BITS + IDX_W;
    localparam int PP_W    = Q15_W + DIGIT_W + 1;

    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_INDEX = 3'd1;
    localparam logic [2:0] P_ROM   = 3'd2;
    localparam logic [2:0] P_MUL   = 3'd3;
    localparam logic [2:0] P_ROUND = 3'd4;

    // One entry of the full-circle sine table, from the quarter-wave polynomial.
    function automatic logic signed [Q15_W-1:0] sine_entry(input int k);
        longint unsigned phase;
        longint unsigned r;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t5;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned quad;
        phase = (longint'(k) << 32) / SINE_TABLE_DEPTH;
        quad  = phase >> 30;
        r     = phase & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            r = 64'h4000_0000 - r;
        end
        t   = r >> 15;
        t2  = (t * t) >> 15;
        t3  = (t2 * t) >> 15;
        t5  = (t3 * t2) >> 15;
        acc = POLY_C1 * t + POLY_C5 * t5 - POLY_C3 * t3;
        s   = acc >> 15;
        if (s > Q15_MAX)
        begin
            s = Q15_MAX;
        end
        return (quad >= 2) ? -Q15_W'(s) : Q15_W'(s);
    endfunction

    // Round a Q15-scaled product to an integer, halves away from zero.
    function automatic logic signed [COORD_W-1:0] round_q15(input logic signed [ACC_W-1:0] p);
        logic [ACC_W-1:0]   mag;
        logic [ACC_W-1:0]   r;
        logic [COORD_W-1:0] rs;
        mag = p[ACC_W-1] ? ACC_W'(-p) : ACC_W'(p);
        r   = (mag + ACC_W'(ROUND_HALF)) >> FRAC_BITS;
        rs  = r[COORD_W-1:0];
        return p[ACC_W-1] ? -$signed(rs) : $signed(rs);
    endfunction

    // Full-circle sine table; every entry is a constant.
    logic signed [Q15_W-1:0]   sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [ANGLE_BITS-1:0]     ang_reg;
    logic [RANGE_W-1:0]        range_sh_reg;
    logic [IDX_W-1:0]          sin_idx_reg, cos_idx_reg;
    logic signed [Q15_W-1:0]   sin_q_reg, cos_q_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    point_t                    point_reg;

    logic [IPROD_W-1:0]        sin_iprod, cos_iprod;
    logic [DIGIT_W-1:0]        digit;
    logic signed [PP_W-1:0]    pp_x, pp_y;

    assign sin_iprod = IPROD_W'(ang_reg) * IPROD_W'(SINE_TABLE_DEPTH);
    assign cos_iprod = IPROD_W'(ang_reg + QUARTER) * IPROD_W'(SINE_TABLE_DEPTH);

    assign digit = range_sh_reg[RANGE_W-1 -: DIGIT_W];
    assign pp_x  = $signed({1'b0, digit}) * cos_q_reg;
    assign pp_y  = $signed({1'b0, digit}) * sin_q_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    state_next = P_INDEX;
                end
            end
            P_INDEX:
            begin
                state_next = P_ROM;
            end
            P_ROM:
            begin
                cnt_next   = '0;
                state_next = P_MUL;
            end
            P_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    state_next = P_ROUND;
                end
            end
            P_ROUND:
            begin
                done_next  = 1'b1;
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == P_IDLE && start)
        begin
            ang_reg      <= ang;
            range_sh_reg <= range_mm;
        end
        if (state_reg == P_INDEX)
        begin
            sin_idx_reg <= sin_iprod[IPROD_W-1 -: IDX_W];
            cos_idx_reg <= cos_iprod[IPROD_W-1 -: IDX_W];
        end
        if (state_reg == P_ROM)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        if (state_reg == P_MUL)
        begin
            acc_x_reg    <= (acc_x_reg <<< DIGIT_W) + ACC_W'(pp_x);
            acc_y_reg    <= (acc_y_reg <<< DIGIT_W) + ACC_W'(pp_y);
            range_sh_reg <= range_sh_reg << DIGIT_W;
        end
        if (state_reg == P_ROUND)
        begin
            point_reg.x <= round_q15(acc_x_reg) + COORD_W'(mount_x_mm);
            point_reg.y <= round_q15(acc_y_reg) + COORD_W'(mount_y_mm);
        end
    end

    // The table is read every cycle; the indexes hold while the products build.
    always_ff @(posedge clk)
    begin
        sin_q_reg <= sine_rom[sin_idx_reg];
        cos_q_reg <= sine_rom[cos_idx_reg];
    end

    assign done  = done_reg;
    assign point = point_reg;

endmodule

// File: rtl/core/lidar_wall_follow_steering.sv
// Reactive wall-following steering controller. Range samples (func 0 in tuser, range in
// tdata, tlast on the final sample of a scan) are turned into points in the robot base frame
// through a sine table and a digit-serial multiplier, and the scan is reduced to the
// forward-most reach of the followed wall and the nearest obstacle ahead. On the last sample
// one command leaves on the master side: speed, turn rate and a decision code; when not
// exploring a single stop command is sent and further scans stay silent. Commands (func 1
// explore, 2 return/halt, 3 ignored) are handled on acceptance. From acceptance to the next
// acceptance a range sample passes the acceptance cycle, the table index, the registered
// table read, four 4-bit steps of the 16-bit range multiply, rounding, the hand-off of the
// finished point and the accumulate step; the last sample of a scan adds the decision, the
// speed division if needed and the hand-off to the output register, and waits while that
// register holds an unaccepted command. Samples are taken one at a time; a finished command
// waits in the output register while the next sample is taken. Write configuration over
// the APB-style port only while the block is idle; the block itself does not enforce this.
module lidar_wall_follow_steering #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ANGLE_BITS       = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] range_mm
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        s_tlast,   // last_sample

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] forward_speed, [19:8] turn_rate, [21:20] decision

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lwfs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POINT  = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // Configuration registers.
    logic                      follow_right_reg;
    logic [CFG_ANG_W-1:0]      start_angle_reg;
    logic [CFG_ANG_W-1:0]      angle_step_reg;
    logic signed [MOUNT_W-1:0] mount_x_reg;
    logic signed [MOUNT_W-1:0] mount_y_reg;
    logic [CFG_ANG_W-1:0]      mount_yaw_reg;

    // Control and scan state.
    logic [2:0]                state_reg, state_next;
    logic                      exploring_reg, exploring_next;
    logic                      stop_sent_reg, stop_sent_next;
    logic [ANGLE_BITS-1:0]     sample_angle_reg, sample_angle_next;
    logic                      side_found_reg, side_found_next;
    logic signed [SIDE_W-1:0]  side_reach_reg, side_reach_next;
    logic [FRONT_W-1:0]        front_reg, front_next;
    logic                      last_reg;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Result under construction and output register.
    logic [PROD_W-1:0]         prod_reg;
    logic [SPEED_W-1:0]        res_speed_reg;
    logic signed [TURN_W-1:0]  res_turn_reg;
    logic [DEC_W-1:0]          res_dec_reg;
    logic [SPEED_W-1:0]        out_speed_reg;
    logic signed [TURN_W-1:0]  out_turn_reg;
    logic [DEC_W-1:0]          out_dec_reg;

    logic                      cfg_we;
    logic                      in_take;
    logic                      pt_start;
    logic                      pt_done;
    point_t                    pt;
    logic [ANGLE_BITS-1:0]     ang;
    logic                      side_hit;
    logic                      front_hit;
    logic                      out_free;

    // Blend arithmetic.
    logic [FRONT_W-1:0]        f_clamp;
    logic [7:0]                f_diff;
    logic [SIDE_W-1:0]         side_plus;
    logic signed [FRONT_W-1:0] turn_base;
    logic signed [VTURN_W-1:0] v_turn;
    logic [VTURN_W-1:0]        v_mag;
    logic [VTURN_W-1:0]        t_half;
    logic signed [TURN_W-1:0]  blend_turn;
    logic [PROD_W-1:0]         speed_num;
    logic [QUOT_W-1:0]         speed_q;
    logic [RECIP_W-1:0]        recip_prod;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_right_reg <= 1'b0;
            start_angle_reg  <= '0;
            angle_step_reg   <= ANGLE_STEP_RESET;
            mount_x_reg      <= '0;
            mount_y_reg      <= '0;
            mount_yaw_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_FOLLOW_RIGHT: follow_right_reg <= pwdata[0];
                REG_START_ANGLE:  start_angle_reg  <= pwdata[CFG_ANG_W-1:0];
                REG_ANGLE_STEP:   angle_step_reg   <= pwdata[CFG_ANG_W-1:0];
                REG_MOUNT_X:      mount_x_reg      <= $signed(pwdata[MOUNT_W-1:0]);
                REG_MOUNT_Y:      mount_y_reg      <= $signed(pwdata[MOUNT_W-1:0]);
                REG_MOUNT_YAW:    mount_yaw_reg    <= pwdata[CFG_ANG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FOLLOW_RIGHT: prdata = {31'b0, follow_right_reg};
            REG_START_ANGLE:  prdata = {16'b0, start_angle_reg};
            REG_ANGLE_STEP:   prdata = {16'b0, angle_step_reg};
            REG_MOUNT_X:      prdata = {21'b0, mount_x_reg};
            REG_MOUNT_Y:      prdata = {21'b0, mount_y_reg};
            REG_MOUNT_YAW:    prdata = {16'b0, mount_yaw_reg};
            default:          prdata = '0;
        endcase
    end

    // Angle of the current sample; the angle registers are used modulo the angle word.
    assign ang = ANGLE_BITS'(start_angle_reg) + sample_angle_reg + ANGLE_BITS'(mount_yaw_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid & s_tready;
    assign pt_start = in_take && (s_tuser == FUNC_SAMPLE);

    lwfs_point #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ANGLE_BITS       (ANGLE_BITS)
    ) u_point (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (pt_start),
        .ang        (ang),
        .range_mm   (s_tdata),
        .mount_x_mm (mount_x_reg),
        .mount_y_mm (mount_y_reg),
        .done       (pt_done),
        .point      (pt)
    );

    // A side point lies within the robot's length and close on the followed side; a front
    // point lies straight ahead within the approach distance.
    assign side_hit = (pt.x >= -COORD_RADIUS) && (pt.x <= COORD_RADIUS) &&
                      (pt.y >= -COORD_SIDE_LIMIT) && (pt.y <= COORD_SIDE_LIMIT) &&
                      (follow_right_reg ? (pt.y < COORD_ZERO) : (pt.y > COORD_ZERO));
    assign front_hit = (pt.x > COORD_ZERO) && (pt.x <= COORD_APPROACH_MX) &&
                       (pt.y >= -COORD_RADIUS) && (pt.y <= COORD_RADIUS) &&
                       (pt.x < $signed({{(COORD_W-FRONT_W){1'b0}}, front_reg}));

    // Blend terms: f is the front distance capped at the approach limit, and the turn is
    // 7*(f - 300 - s)/2 rounded with halves away from zero.
    assign f_clamp    = (front_reg > FRONT_APPROACH_MX) ? FRONT_APPROACH_MX : front_reg;
    assign f_diff     = 8'(f_clamp - FRONT_APPROACH_MN);
    assign side_plus  = RADIUS_U + side_reach_reg;
    assign turn_base  = $signed({2'b00, f_diff}) - FRONT_W'(side_reach_reg);
    assign v_turn     = (VTURN_W'(turn_base) <<< 3) - VTURN_W'(turn_base);
    assign v_mag      = v_turn[VTURN_W-1] ? VTURN_W'(-v_turn) : VTURN_W'(v_turn);
    assign t_half     = (v_mag + VTURN_W'(1)) >> 1;
    assign blend_turn = v_turn[VTURN_W-1] ? -$signed(t_half[TURN_W-1:0])
                                          : $signed(t_half[TURN_W-1:0]);

    // Speed is (prod + 160) / 320: a shift by 6 (division by 64), then division by 5 through its reciprocal.
    assign speed_num  = prod_reg + PROD_W'(SPEED_BIAS);
    assign speed_q    = speed_num[PROD_W-1:SPEED_PRE_SHIFT];
    assign recip_prod = RECIP_W'(speed_q) * RECIP_W'(RECIP5);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next        = state_reg;
        exploring_next    = exploring_reg;
        stop_sent_next    = stop_sent_reg;
        sample_angle_next = sample_angle_reg;
        side_found_next   = side_found_reg;
        side_reach_next   = side_reach_reg;
        front_next        = front_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (s_tuser)
                        FUNC_SAMPLE:
                        begin
                            sample_angle_next = sample_angle_reg + ANGLE_BITS'(angle_step_reg);
                            state_next        = ST_POINT;
                        end
                        FUNC_EXPLORE:
                        begin
                            exploring_next = 1'b1;
                        end
                        FUNC_HALT:
                        begin
                            exploring_next = 1'b0;
                            stop_sent_next = 1'b0;
                        end
                        default:
                        begin
                            exploring_next = exploring_reg;
                        end
                    endcase
                end
            end
            ST_POINT:
            begin
                if (pt_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (side_hit)
                begin
                    if (!side_found_reg || (pt.x > COORD_W'(side_reach_reg)))
                    begin
                        side_reach_next = pt.x[SIDE_W-1:0];
                    end
                    side_found_next = 1'b1;
                end
                if (front_hit)
                begin
                    front_next = pt.x[FRONT_W-1:0];
                end
                state_next = last_reg ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
            begin
                if (!exploring_reg && stop_sent_reg)
                begin
                    // Stop already sent: the scan is dropped silently.
                    sample_angle_next = '0;
                    side_found_next   = 1'b0;
                    side_reach_next   = '0;
                    front_next        = FRONT_NONE;
                    state_next        = ST_IDLE;
                end
                else if (exploring_reg && side_found_reg && (front_reg > FRONT_APPROACH_MN))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next     = 1'b1;
                    stop_sent_next    = !exploring_reg;
                    sample_angle_next = '0;
                    side_found_next   = 1'b0;
                    side_reach_next   = '0;
                    front_next        = FRONT_NONE;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            exploring_reg    <= 1'b0;
            stop_sent_reg    <= 1'b0;
            sample_angle_reg <= '0;
            side_found_reg   <= 1'b0;
            side_reach_reg   <= '0;
            front_reg        <= FRONT_NONE;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            exploring_reg    <= exploring_next;
            stop_sent_reg    <= stop_sent_next;
            sample_angle_reg <= sample_angle_next;
            side_found_reg   <= side_found_next;
            side_reach_reg   <= side_reach_next;
            front_reg        <= front_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Payload registers for the command being built and the one on the output.
    always_ff @(posedge clk)
    begin
        if (pt_start)
        begin
            last_reg <= s_tlast;
        end
        if (state_reg == ST_DECIDE)
        begin
            prod_reg <= {8'b0, side_plus} * {9'b0, f_diff};
            if (!exploring_reg)
            begin
                res_speed_reg <= '0;
                res_turn_reg  <= '0;
                res_dec_reg   <= DEC_STOP;
            end
            else if (!side_found_reg)
            begin
                res_speed_reg <= '0;
                res_turn_reg  <= follow_right_reg ? -TURN_MAX : TURN_MAX;
                res_dec_reg   <= DEC_NO_SIDE;
            end
            else if (front_reg <= FRONT_APPROACH_MN)
            begin
                res_speed_reg <= '0;
                res_turn_reg  <= follow_right_reg ? TURN_MAX : -TURN_MAX;
                res_dec_reg   <= DEC_BLOCKED;
            end
            else
            begin
                res_turn_reg <= follow_right_reg ? -blend_turn : blend_turn;
                res_dec_reg  <= DEC_BLEND;
            end
        end
        if (state_reg == ST_DIV)
        begin
            res_speed_reg <= recip_prod[RECIP_SHIFT +: SPEED_W];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_speed_reg <= res_speed_reg;
            out_turn_reg  <= res_turn_reg;
            out_dec_reg   <= res_dec_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_dec_reg, out_turn_reg, out_speed_reg};

endmodule

// File: verif/tb_lidar_wall_follow_steering.sv
`timescale 1ns / 1ps

module tb_lidar_wall_follow_steering;
    import lwfs_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ANGLE_BITS_P = 16;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    // The pause before a register write covers a range sample and a scan end once the output
    // is free, with margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 75;
    localparam int PHASES        = 8;
    localparam int MAX_REPORTS   = 10;

    // Register index past the end of the map; writes to it must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd6;

    // Quarter turn of a 16-bit binary angle, used to turn a sine lookup into a cosine.
    localparam logic [CFG_ANG_W-1:0] QUARTER_TURN = 16'h4000;

    // Geometry and steering limits in millimetres and milliradians per second.
    localparam int RADIUS_MM      = 200;
    localparam int SIDE_LIMIT_MM  = 500;
    localparam int APPROACH_MIN   = 300;
    localparam int APPROACH_MAX   = 500;
    localparam int TURN_LIMIT     = 1400;
    localparam int NOTHING_AHEAD  = 1023;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed;
        logic signed [TURN_W-1:0]  turn;
        logic [DEC_W-1:0]          decision;
    } steer_cmd_t;

    // Keeps a private copy of the registers and of the scan accumulators, works out the
    // steering command that each accepted transaction causes and compares the commands
    // that leave the block against them in order.
    class steer_scoreboard;
        steer_cmd_t pending_cmds[$];
        int failures;
        int samples;
        int commands;
        int dec_seen[4];

        bit                   follow_right;
        logic [CFG_ANG_W-1:0] start_angle;
        logic [CFG_ANG_W-1:0] angle_step;
        logic [CFG_ANG_W-1:0] mount_yaw;
        int                   mount_x;
        int                   mount_y;

        bit                   exploring;
        bit                   stop_sent;
        bit                   side_found;
        logic [CFG_ANG_W-1:0] sample_angle;
        int                   side_reach;
        int                   front_nearest;

        function new();
            follow_right = 1'b0;
            start_angle  = '0;
            angle_step   = ANGLE_STEP_RESET;
            mount_yaw    = '0;
            mount_x      = 0;
            mount_y      = 0;
            exploring    = 1'b0;
            stop_sent    = 1'b0;
            failures     = 0;
            samples      = 0;
            commands     = 0;
            foreach (dec_seen[i])
                dec_seen[i] = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            sample_angle  = '0;
            side_found    = 1'b0;
            side_reach    = 0;
            front_nearest = NOTHING_AHEAD;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_FOLLOW_RIGHT: follow_right = value[0];
                REG_START_ANGLE:  start_angle  = value[15:0];
                REG_ANGLE_STEP:   angle_step   = value[15:0];
                REG_MOUNT_X:      mount_x      = int'($signed(value[MOUNT_W-1:0]));
                REG_MOUNT_Y:      mount_y      = int'($signed(value[MOUNT_W-1:0]));
                REG_MOUNT_YAW:    mount_yaw    = value[15:0];
                default: ;
            endcase
        endfunction

        // Q0.15 sine of a binary angle from the quarter-wave polynomial, folded by quadrant.
        function int sine_q15(logic [CFG_ANG_W-1:0] ang);
            longint unsigned a, idx, phase, r, t, t2, t3, t5, acc, s;
            a     = ang;
            idx   = (a * TABLE_DEPTH) >> ANGLE_BITS_P;
            phase = (idx << 32) / TABLE_DEPTH;
            r     = phase & 64'h3FFF_FFFF;
            if (phase[30])
                r = 64'h4000_0000 - r;
            t   = r >> 15;
            t2  = (t * t) >> 15;
            t3  = (t2 * t) >> 15;
            t5  = (t3 * t2) >> 15;
            acc = POLY_C1 * t + POLY_C5 * t5 - POLY_C3 * t3;
            s   = acc >> FRAC_BITS;
            if (s > Q15_MAX)
                s = Q15_MAX;
            return phase[31] ? -int'(s) : int'(s);
        endfunction

        // Drop 15 fraction bits, halves rounded away from zero.
        function int round_q15(longint p);
            if (p >= 0)
                return int'((p + ROUND_HALF) >>> FRAC_BITS);
            return -int'((-p + ROUND_HALF) >>> FRAC_BITS);
        endfunction

        function void predict_command(logic [FUNC_W-1:0] func, logic [RANGE_W-1:0] rng_mm,
                                      logic last);
            logic [CFG_ANG_W-1:0] ang;
            int x, y, ax, ay, fcap, v, speed, turn;
            steer_cmd_t cmd;
            if (func == FUNC_EXPLORE)
            begin
                exploring = 1'b1;
                return;
            end
            if (func == FUNC_HALT)
            begin
                exploring = 1'b0;
                stop_sent = 1'b0;
                return;
            end
            if (func == FUNC_OTHER)
                return;

            samples++;
            ang = start_angle + sample_angle + mount_yaw;
            x = round_q15(longint'(rng_mm) * sine_q15(ang + QUARTER_TURN)) + mount_x;
            y = round_q15(longint'(rng_mm) * sine_q15(ang)) + mount_y;
            sample_angle = sample_angle + angle_step;

            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            // Wall point beside the robot on the followed side.
            if (ax <= RADIUS_MM && ay <= SIDE_LIMIT_MM && (follow_right ? (y < 0) : (y > 0)))
            begin
                if (!side_found || x > side_reach)
                    side_reach = x;
                side_found = 1'b1;
            end
            // Obstacle inside the corridor straight ahead.
            if (x > 0 && x <= APPROACH_MAX && ay <= RADIUS_MM && x < front_nearest)
                front_nearest = x;

            if (!last)
                return;

            if (!exploring)
            begin
                clear_scan();
                if (stop_sent)
                    return;
                stop_sent    = 1'b1;
                cmd.speed    = '0;
                cmd.turn     = '0;
                cmd.decision = DEC_STOP;
                pending_cmds.push_back(cmd);
                return;
            end

            if (!side_found)
            begin
                speed        = 0;
                turn         = TURN_LIMIT;
                cmd.decision = DEC_NO_SIDE;
            end
            else if (front_nearest <= APPROACH_MIN)
            begin
                speed        = 0;
                turn         = -TURN_LIMIT;
                cmd.decision = DEC_BLOCKED;
            end
            else
            begin
                fcap  = (front_nearest > APPROACH_MAX) ? APPROACH_MAX : front_nearest;
                v     = 7 * (fcap - APPROACH_MIN - side_reach);
                speed = ((RADIUS_MM + side_reach) * (fcap - APPROACH_MIN) + 160) / 320;
                turn  = (v >= 0) ? (v + 1) / 2 : -((-v + 1) / 2);
                cmd.decision = DEC_BLEND;
            end
            if (follow_right)
                turn = -turn;
            cmd.speed = speed[SPEED_W-1:0];
            cmd.turn  = turn[TURN_W-1:0];
            clear_scan();
            stop_sent = 1'b0;
            pending_cmds.push_back(cmd);
        endfunction

        function void compare_command(logic [23:0] data);
            steer_cmd_t want;
            logic [SPEED_W-1:0] got_speed;
            logic [TURN_W-1:0]  got_turn;
            logic [DEC_W-1:0]   got_dec;
            got_speed = data[7:0];
            got_turn  = data[19:8];
            got_dec   = data[21:20];
            commands++;
            if (pending_cmds.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected command speed %0d turn %0d decision %0d",
                             $realtime, got_speed, $signed(got_turn), got_dec);
                return;
            end
            want = pending_cmds.pop_front();
            dec_seen[want.decision]++;
            if (got_speed !== want.speed || got_turn !== want.turn ||
                got_dec !== want.decision)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $write("%0t: command mismatch: expected speed %0d turn %0d decision %0d,",
                           $realtime, want.speed, want.turn, want.decision);
                    $display(" got speed %0d turn %0d decision %0d",
                             got_speed, $signed(got_turn), got_dec);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    steer_scoreboard sb = new();

    // Idling controls: allow_idle switches both sides off for the closing part of the run,
    // and the two burst enables are redrawn for every scan so that quiet stretches occur.
    bit allow_idle;
    bit src_gaps;
    bit sink_stalls;
    int settings_used;
    int cycle_count = 0;

    lidar_wall_follow_steering #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH),
        .ANGLE_BITS(ANGLE_BITS_P)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d commands outstanding",
                     cycle_count, sb.pending());
            $display("tb_lidar_wall_follow_steering: done, errors");
            $finish;
        end
    end

    // Every command transaction on the master side is checked against the oldest
    // prediction. Values are read at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.compare_command(m_tdata);
    end

    // Result side back-pressure: tready drops in random bursts.
    initial
    begin : result_sink
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (allow_idle && sink_stalls && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offers one item on the slave side and returns at the falling edge after the
    // transaction. It is entered at a falling edge; tvalid stays high between items
    // unless a gap is inserted, so each signal gets at most one update per edge.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [RANGE_W-1:0] rng_mm,
                             input logic last);
        if (allow_idle && src_gaps && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= rng_mm;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.predict_command(func, rng_mm, last);
        @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready, then an idle phase with psel
    // low, so that back-to-back writes never update the bus twice at one edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering items and wait until the block has delivered every predicted command
    // and finished any sample that produces none, so that registers may change.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input bit fr, input logic [15:0] start,
                                  input logic [15:0] step, input int mx, input int my,
                                  input logic [15:0] yaw);
        write_reg(REG_FOLLOW_RIGHT, {31'd0, fr});
        write_reg(REG_START_ANGLE, {16'd0, start});
        write_reg(REG_ANGLE_STEP, {16'd0, step});
        write_reg(REG_MOUNT_X, mx);
        write_reg(REG_MOUNT_Y, my);
        write_reg(REG_MOUNT_YAW, {16'd0, yaw});
        settings_used++;
    endtask

    // Ranges are mostly short so that points land near the robot and feed the side and
    // front trackers; the rest reach the extremes and far returns.
    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return RANGE_W'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return RANGE_W'($urandom_range(0, 700));
        endcase
    endfunction

    // Whole scans of random length and content, with explore, halt and ignored commands
    // scattered in between samples. The phase always ends on a scan boundary.
    task automatic run_scans(input int n_items);
        int sent;
        int scan_len;
        int k;
        logic [FUNC_W-1:0] func;
        sent = 0;
        while (sent < n_items)
        begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            scan_len    = $urandom_range(1, 12);
            for (k = 0; k < scan_len; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       func = FUNC_HALT;
                        1:       func = FUNC_OTHER;
                        default: func = FUNC_EXPLORE;
                    endcase
                    send_item(func, RANGE_W'($urandom), 1'($urandom_range(0, 1)));
                    if (func != FUNC_OTHER)
                        sent++;
                end
                send_item(FUNC_SAMPLE, pick_range(), k == scan_len - 1);
                sent++;
            end
        end
    endtask

    function automatic int random_mount();
        if ($urandom_range(0, 4) == 0)
            return int'($urandom_range(0, 2000)) - 1000;
        return int'($urandom_range(0, 300)) - 150;
    endfunction

    function automatic logic [15:0] random_step();
        case ($urandom_range(0, 3))
            0:       return 16'd2048;
            1:       return 16'd4096;
            2:       return 16'd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int p;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = FUNC_SAMPLE;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        allow_idle    = 1'b1;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        settings_used = 1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, not exploring: the first scan end gives a single stop command,
        // the next scan end stays silent. An ignored command and an explore follow, and a
        // far return straight ahead leaves no wall beside the robot.
        send_item(FUNC_SAMPLE, 16'd1000, 1'b0);
        send_item(FUNC_SAMPLE, 16'd500, 1'b1);
        send_item(FUNC_SAMPLE, 16'd0, 1'b1);
        send_item(FUNC_OTHER, 16'hFFFF, 1'b1);
        send_item(FUNC_EXPLORE, 16'h0000, 1'b0);
        send_item(FUNC_SAMPLE, 16'hFFFF, 1'b1);
        wait_idle();

        // Quarter-turn steps put samples at ahead, left, behind and right.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_ANGLE_STEP, 32'd16384);
        settings_used++;

        // Obstacle ahead at 250 mm with a wall on the left: blocked front.
        send_item(FUNC_SAMPLE, 16'd250, 1'b0);
        send_item(FUNC_SAMPLE, 16'd300, 1'b1);
        // Obstacle exactly at the corridor's far edge and a wall at 200 mm: blend.
        send_item(FUNC_SAMPLE, 16'd500, 1'b0);
        send_item(FUNC_SAMPLE, 16'd200, 1'b1);
        // Front just past the blocking distance, wall at the side limit, a zero range and
        // a point on the other side: blend with the smallest speed.
        send_item(FUNC_SAMPLE, 16'd301, 1'b0);
        send_item(FUNC_SAMPLE, 16'd500, 1'b0);
        send_item(FUNC_SAMPLE, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'd200, 1'b1);
        // Halt gives one stop; explore again, then only far returns.
        send_item(FUNC_HALT, 16'h0000, 1'b0);
        send_item(FUNC_SAMPLE, 16'd100, 1'b1);
        send_item(FUNC_EXPLORE, 16'h0000, 1'b0);
        send_item(FUNC_SAMPLE, 16'hFFFF, 1'b0);
        send_item(FUNC_SAMPLE, 16'hFFFF, 1'b1);
        wait_idle();

        // Right-hand wall following: a wall on the right and nothing ahead.
        write_reg(REG_FOLLOW_RIGHT, 32'd1);
        settings_used++;
        send_item(FUNC_SAMPLE, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'd150, 1'b0);
        send_item(FUNC_SAMPLE, 16'd400, 1'b1);
        wait_idle();

        // Random phases, each under its own register settings, extremes first. The last
        // phase runs with both sides at full rate.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_settings(1'b0, 16'h0000, 16'd4096, 0, 0, 16'h0000);
                1: apply_settings(1'b1, 16'h0000, 16'd4096, 0, 0, 16'h0000);
                2: apply_settings(1'b0, 16'hFFFF, 16'hFFFF, -1000, 1000, 16'hFFFF);
                3: apply_settings(1'b1, 16'hC000, 16'h0000, 1000, -1000, 16'h8000);
                default: apply_settings(1'($urandom_range(0, 1)), 16'($urandom),
                                        random_step(), random_mount(), random_mount(),
                                        16'($urandom));
            endcase
            if (p == PHASES - 1)
                allow_idle = 1'b0;
            run_scans(PHASE_ITEMS);
            wait_idle();
        end

        $display("Covered %0d range samples over %0d register settings, %0d commands seen.",
                 sb.samples, settings_used, sb.commands);
        $write("Commands by decision: stop %0d, no side wall %0d, ",
               sb.dec_seen[DEC_STOP], sb.dec_seen[DEC_NO_SIDE]);
        $display("front blocked %0d, blend %0d; failures %0d.",
                 sb.dec_seen[DEC_BLOCKED], sb.dec_seen[DEC_BLEND], sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_lidar_wall_follow_steering: done, clean");
        else
            $display("tb_lidar_wall_follow_steering: done, errors");
        $finish;
    end

endmodule
